[rtl/btlv_pkg.sv]
// ----------------------------------------------------------------------------
// btlv_pkg: shared types and constants for the BER-TLV stream parser
// Phase codes, result kinds, error codes, nesting limits, and the structs
// that run between the parser core and its row of level cells.
// ----------------------------------------------------------------------------
package btlv_pkg;

	// nesting limit and level indexing (level 0 is the whole buffer)
	localparam int MAX_DEPTH = 8;
	localparam int LEVELS    = MAX_DEPTH + 1;
	localparam int LVL_W     = $clog2(LEVELS);
	localparam int DEPTH_W   = 4;

	// port widths
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 64;

	// parse phase codes
	localparam logic [2:0] PH_TAG1  = 3'd0;
	localparam logic [2:0] PH_TAGN  = 3'd1;
	localparam logic [2:0] PH_LEN1  = 3'd2;
	localparam logic [2:0] PH_LENN  = 3'd3;
	localparam logic [2:0] PH_VALUE = 3'd4;

	// result kinds
	localparam logic [2:0] KIND_HDR_BYTE = 3'd0;
	localparam logic [2:0] KIND_HDR_DONE = 3'd1;
	localparam logic [2:0] KIND_VALUE    = 3'd2;
	localparam logic [2:0] KIND_SKIP     = 3'd3;
	localparam logic [2:0] KIND_ERROR    = 3'd4;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_TAG_LONG = 3'd1;
	localparam logic [2:0] ERR_BAD_LEN  = 3'd2;
	localparam logic [2:0] ERR_TRUNC    = 3'd3;
	localparam logic [2:0] ERR_OVERRUN  = 3'd4;

	// tag / length header byte masks
	localparam logic [7:0] TAG_NUM_MASK  = 8'h1F;
	localparam logic [7:0] LEN_LONG_1    = 8'h81;
	localparam logic [7:0] LEN_LONG_2    = 8'h82;
	localparam logic [1:0] TAG_EXTRA_MAX = 2'd3;

	// per-item request broadcast to every level cell
	typedef struct packed {
		logic             go;
		logic             start;
		logic [15:0]      blen;
		logic [LVL_W-1:0] d;
	} lvl_req_t;

	// per-item update broadcast to every level cell
	typedef struct packed {
		logic        run;
		logic        open;
		logic [15:0] open_len;
		logic        err;
	} lvl_upd_t;

	// level cell status back to the core
	typedef struct packed {
		logic        live;
		logic [15:0] rem;
		logic        nz;
		logic        skip;
	} lvl_sts_t;

	// one result item
	typedef struct packed {
		logic [2:0]         kind;
		logic [31:0]        tag;
		logic [15:0]        length;
		logic               constructed;
		logic [DEPTH_W-1:0] depth;
		logic [7:0]         value_byte;
		logic [2:0]         error_code;
		logic               buffer_end;
	} item_t;

endpackage

[rtl/btlv_level_cell.sv]
// ----------------------------------------------------------------------------
// btlv_level_cell: one nesting level of the parser
// Holds the remaining byte count and the skip flag of its level, counts down
// while the level encloses the current element, and reloads when opened.
// ----------------------------------------------------------------------------
module btlv_level_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [btlv_pkg::LVL_W-1:0] idx,
	input  btlv_pkg::lvl_req_t      req,
	input  btlv_pkg::lvl_upd_t      upd,
	output btlv_pkg::lvl_sts_t      sts
);
	import btlv_pkg::*;

	logic [15:0]      rem_q;
	logic             skip_q;
	logic [15:0]      cur;
	logic             skp;
	logic             active;
	logic [15:0]      dec;
	logic [LVL_W-1:0] d_up;
	logic             popped;
	logic             is_child;

	// effective view after an optional restart, then the count-down
	always_comb begin
		cur      = req.start ? ((idx == '0) ? req.blen : 16'd0) : rem_q;
		skp      = req.start ? 1'b0 : skip_q;
		active   = (idx <= req.d);
		dec      = (active && cur != 16'd0) ? cur - 16'd1 : cur;
		d_up     = req.d + 1'b1;
		is_child = upd.open && (idx == d_up);
		popped   = !upd.open && (idx != '0) && active && (dec == 16'd0);
	end

	assign sts.live = (cur != 16'd0);
	assign sts.rem  = dec;
	assign sts.nz   = (dec != 16'd0);
	assign sts.skip = skp;

	// level state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= 16'd0;
			skip_q <= 1'b0;
		end else if (req.go) begin
			if (!upd.run) begin
				rem_q  <= cur;
				skip_q <= skp;
			end else begin
				rem_q <= is_child ? upd.open_len : dec;
				if (popped || is_child)
					skip_q <= 1'b0;
				else if (upd.err && idx == req.d)
					skip_q <= 1'b1;
				else
					skip_q <= skp;
			end
		end
	end

endmodule

[rtl/btlv_core.sv]
// ----------------------------------------------------------------------------
// btlv_core: header/value phase logic and the row of level cells
// Decodes one byte per accepted item into one result, updates the tag and
// length accumulators, and opens and closes nesting levels.
// ----------------------------------------------------------------------------
module btlv_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          acc,
	input  logic [7:0]    data_byte,
	input  logic          start_req,
	input  logic [15:0]   buffer_len,
	output btlv_pkg::item_t res
);
	import btlv_pkg::*;

	logic [2:0]       phase_q, phase_e, phase_n;
	logic [31:0]      tag_q, tag_e, tag_n;
	logic [1:0]       tcnt_q, tcnt_e, tcnt_n;
	logic [15:0]      len_q, len_e, len_n;
	logic [1:0]       lbl_q, lbl_e, lbl_n;
	logic             cons_q, cons_e, cons_n;
	logic [LVL_W-1:0] depth_q, d, depth_n;
	logic [15:0]      vleft_q, vleft_e, vleft_n;

	lvl_req_t         req;
	lvl_upd_t         upd;
	lvl_sts_t         sts [LEVELS];

	logic             live0;
	logic [15:0]      left;
	logic             skipping;
	logic             complete;
	logic             open;
	logic [2:0]       err;

	// restart view of the registers
	always_comb begin
		phase_e = start_req ? PH_TAG1 : phase_q;
		tag_e   = start_req ? 32'd0 : tag_q;
		tcnt_e  = start_req ? 2'd0 : tcnt_q;
		len_e   = start_req ? 16'd0 : len_q;
		lbl_e   = start_req ? 2'd0 : lbl_q;
		cons_e  = start_req ? 1'b0 : cons_q;
		d       = start_req ? '0 : depth_q;
		vleft_e = start_req ? 16'd0 : vleft_q;
	end

	assign req.go    = acc;
	assign req.start = start_req;
	assign req.blen  = buffer_len;
	assign req.d     = d;

	// row of level cells
	for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
		btlv_level_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (LVL_W'(g)),
			.req    (req),
			.upd    (upd),
			.sts    (sts[g])
		);
	end

	assign live0    = sts[0].live;
	assign left     = sts[d].rem;
	assign skipping = sts[d].skip;

	// byte decode, header completion, errors and level closing
	always_comb begin
		phase_n  = phase_e;
		tag_n    = tag_e;
		tcnt_n   = tcnt_e;
		len_n    = len_e;
		lbl_n    = lbl_e;
		cons_n   = cons_e;
		depth_n  = d;
		vleft_n  = vleft_e;
		res      = '0;
		res.kind = KIND_SKIP;
		complete = 1'b0;
		open     = 1'b0;
		err      = ERR_NONE;
		if (live0) begin
			res.kind  = KIND_HDR_BYTE;
			res.depth = DEPTH_W'(d);
			if (skipping) begin
				res.kind = KIND_SKIP;
			end else begin
				unique case (phase_e)
					PH_TAGN: begin
						tag_n  = {tag_e[23:0], data_byte};
						tcnt_n = tcnt_e + 2'd1;
						if (data_byte[7] && tcnt_n == TAG_EXTRA_MAX) begin
							err = ERR_TAG_LONG;
						end else begin
							if (!data_byte[7])
								phase_n = PH_LEN1;
							if (left == 16'd0)
								err = ERR_TRUNC;
						end
					end
					PH_LEN1: begin
						if (!data_byte[7]) begin
							len_n    = {8'd0, data_byte};
							complete = 1'b1;
						end else if (data_byte == LEN_LONG_1 || data_byte == LEN_LONG_2) begin
							len_n   = 16'd0;
							lbl_n   = data_byte[1:0];
							phase_n = PH_LENN;
							if (left == 16'd0)
								err = ERR_TRUNC;
						end else begin
							err = ERR_BAD_LEN;
						end
					end
					PH_LENN: begin
						len_n = {len_e[7:0], data_byte};
						lbl_n = (lbl_e != 2'd0) ? lbl_e - 2'd1 : 2'd0;
						if (lbl_n == 2'd0)
							complete = 1'b1;
						else if (left == 16'd0)
							err = ERR_TRUNC;
					end
					PH_VALUE: begin
						res.kind       = KIND_VALUE;
						res.value_byte = data_byte;
						vleft_n        = (vleft_e != 16'd0) ? vleft_e - 16'd1 : 16'd0;
						if (vleft_n == 16'd0)
							phase_n = PH_TAG1;
					end
					default: begin
						tag_n   = {24'd0, data_byte};
						tcnt_n  = 2'd0;
						cons_n  = data_byte[5];
						phase_n = ((data_byte & TAG_NUM_MASK) == TAG_NUM_MASK) ?
							PH_TAGN : PH_LEN1;
						if (left == 16'd0)
							err = ERR_TRUNC;
					end
				endcase
			end

			// completed header
			if (complete) begin
				if (len_n > left) begin
					err = ERR_OVERRUN;
				end else begin
					res.kind        = KIND_HDR_DONE;
					res.tag         = tag_n;
					res.length      = len_n;
					res.constructed = cons_n;
					phase_n         = PH_TAG1;
					if (len_n != 16'd0) begin
						if (cons_n && d < LVL_W'(MAX_DEPTH)) begin
							open = 1'b1;
						end else begin
							vleft_n = len_n;
							phase_n = PH_VALUE;
						end
					end
				end
			end

			if (err != ERR_NONE) begin
				res.kind       = KIND_ERROR;
				res.error_code = err;
				phase_n        = PH_TAG1;
			end

			// new depth: deepest enclosing level with bytes left
			if (open) begin
				depth_n = d + 1'b1;
			end else begin
				depth_n = '0;
				for (int i = 1; i < LEVELS; i++) begin
					if (LVL_W'(i) <= d && sts[i].nz)
						depth_n = LVL_W'(i);
				end
				if (depth_n != d)
					phase_n = PH_TAG1;
			end

			if (!sts[0].nz) begin
				res.buffer_end = 1'b1;
				phase_n        = PH_TAG1;
			end
		end
	end

	assign upd.run      = live0;
	assign upd.open     = open;
	assign upd.open_len = len_n;
	assign upd.err      = (err != ERR_NONE);

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG1;
			tag_q   <= 32'd0;
			tcnt_q  <= 2'd0;
			len_q   <= 16'd0;
			lbl_q   <= 2'd0;
			cons_q  <= 1'b0;
			depth_q <= '0;
			vleft_q <= 16'd0;
		end else if (acc) begin
			phase_q <= phase_n;
			tag_q   <= tag_n;
			tcnt_q  <= tcnt_n;
			len_q   <= len_n;
			lbl_q   <= lbl_n;
			cons_q  <= cons_n;
			depth_q <= depth_n;
			vleft_q <= vleft_n;
		end
	end

endmodule

[rtl/ber_tlv_stream_parser.sv]
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser: streaming BER-TLV parser, one byte per item
// Top level: parser core plus a two-entry output buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one buffer byte per item. s_tuser marks the first byte
//   of a new buffer; buffer_len rides with every byte and is sampled only on
//   that first byte. A restart abandons any buffer still being parsed.
//   Output channel m_*: exactly one result item per input item, in order.
//   m_tuser gives the kind (header byte, header complete, value byte,
//   skipped, error); m_tlast flags the byte that exhausts the buffer.
//   Each result is held in the main output register, or in the skid register
//   while the output stalls. Throughput: one byte per cycle while s_tready is
//   high; each byte updates the phase registers and the row of level counters.
//   Stall: the output keeps a main register and a skid register, so one more
//   byte is taken while a result waits; s_tready drops only when both hold.
//   Reset: clears the parse state and all level counters; bytes that arrive
//   before any buffer start come out as skipped items.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [btlv_pkg::IN_DATA_W-1:0]    s_tdata,  // data_byte[7:0], buffer_len[23:8]
	input  logic [0:0]                        s_tuser,  // start_req[0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [btlv_pkg::OUT_DATA_W-1:0]   m_tdata,  // tag[31:0], length[47:32],
	                                                    // constructed[48], depth[52:49],
	                                                    // value_byte[60:53], error_code[63:61]
	output logic [2:0]                        m_tuser,  // kind[2:0]
	output logic                              m_tlast   // buffer_end
);
	import btlv_pkg::*;

	logic  acc;
	item_t res;
	item_t out_q;
	item_t skid_q;
	logic  out_v_q;
	logic  skid_v_q;
	logic  out_free;

	assign s_tready = !skid_v_q;
	assign acc      = s_tvalid && s_tready;
	assign out_free = !out_v_q || m_tready;

	btlv_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.data_byte  (s_tdata[7:0]),
		.start_req  (s_tuser[0]),
		.buffer_len (s_tdata[23:8]),
		.res        (res)
	);

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= acc;
			end
		end else if (acc) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (acc)
				out_q <= res;
		end else if (acc) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.buffer_end;
	assign m_tdata  = {out_q.error_code, out_q.value_byte, out_q.depth,
		out_q.constructed, out_q.length, out_q.tag};

endmodule

[bench/ber_tlv_stream_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser_tb: self-checking bench for the BER-TLV byte parser
// Drives one buffer byte per item. A directed table comes first, then random
// TLV buffers, some of them damaged, plus pure noise. Every result item is
// checked against its table entry or an in-bench parser model. Both sides stall at random.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser_tb;
	import btlv_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_ITEMS  = 1300;
	localparam int HOLD_CYCLES = 60;
	localparam int DIR_ROWS    = 28;

	// one directed row: input byte, and where typed, the result it must give
	typedef struct packed {
		logic        start;
		logic [15:0] blen;
		logic [7:0]  data;
		logic        typed;
		item_t       want;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// byte before any buffer start
		'{0, 'h0000, 'h00, 1, '{KIND_SKIP, 0, 0, 0, 0, 0, ERR_NONE, 0}},
		// 3-byte buffer: tag, short length, one value byte
		'{1, 'h0003, 'h5A, 1, '{KIND_HDR_BYTE, 0, 0, 0, 0, 0, ERR_NONE, 0}},
		'{0, 'h0000, 'h01, 1, '{KIND_HDR_DONE, 'h5A, 1, 0, 0, 0, ERR_NONE, 0}},
		'{0, 'h0000, 'hFF, 1, '{KIND_VALUE, 0, 0, 0, 0, 'hFF, ERR_NONE, 1}},
		// byte after the buffer is used up
		'{0, 'h0000, 'h33, 1, '{KIND_SKIP, 0, 0, 0, 0, 0, ERR_NONE, 0}},
		// largest buffer, tag too long, then skipped
		'{1, 'hFFFF, 'h9F, 1, '{KIND_HDR_BYTE, 0, 0, 0, 0, 0, ERR_NONE, 0}},
		'{0, 'h0000, 'h81, 1, '{KIND_HDR_BYTE, 0, 0, 0, 0, 0, ERR_NONE, 0}},
		'{0, 'h0000, 'h82, 1, '{KIND_HDR_BYTE, 0, 0, 0, 0, 0, ERR_NONE, 0}},
		'{0, 'h0000, 'h83, 1, '{KIND_ERROR, 0, 0, 0, 0, 0, ERR_TAG_LONG, 0}},
		'{0, 'h0000, 'h00, 1, '{KIND_SKIP, 0, 0, 0, 0, 0, ERR_NONE, 0}},
		// restart while active, header cut off inside the tag
		'{1, 'h0002, 'h7F, 1, '{KIND_HDR_BYTE, 0, 0, 0, 0, 0, ERR_NONE, 0}},
		'{0, 'h0000, 'h81, 1, '{KIND_ERROR, 0, 0, 0, 0, 0, ERR_TRUNC, 1}},
		// one-byte buffer
		'{1, 'h0001, 'h01, 1, '{KIND_ERROR, 0, 0, 0, 0, 0, ERR_TRUNC, 1}},
		// indefinite length form
		'{1, 'h0003, 'h04, 1, '{KIND_HDR_BYTE, 0, 0, 0, 0, 0, ERR_NONE, 0}},
		'{0, 'h0000, 'h80, 1, '{KIND_ERROR, 0, 0, 0, 0, 0, ERR_BAD_LEN, 0}},
		'{0, 'h0000, 'h84, 1, '{KIND_SKIP, 0, 0, 0, 0, 0, ERR_NONE, 1}},
		// header cut off inside a two-byte length
		'{1, 'h0003, 'h30, 1, '{KIND_HDR_BYTE, 0, 0, 0, 0, 0, ERR_NONE, 0}},
		'{0, 'h0000, 'h82, 1, '{KIND_HDR_BYTE, 0, 0, 0, 0, 0, ERR_NONE, 0}},
		'{0, 'h0000, 'hAB, 1, '{KIND_ERROR, 0, 0, 0, 0, 0, ERR_TRUNC, 1}},
		// value longer than the buffer
		'{1, 'h0003, 'h21, 1, '{KIND_HDR_BYTE, 0, 0, 0, 0, 0, ERR_NONE, 0}},
		'{0, 'h0000, 'h05, 1, '{KIND_ERROR, 0, 0, 0, 0, 0, ERR_OVERRUN, 0}},
		'{0, 'h0000, 'h00, 1, '{KIND_SKIP, 0, 0, 0, 0, 0, ERR_NONE, 1}},
		// constructed element holding one primitive
		'{1, 'h0006, 'h61, 0, '0},
		'{0, 'h0000, 'h04, 0, '0},
		'{0, 'h0000, 'h02, 0, '0},
		'{0, 'h0000, 'h02, 0, '0},
		'{0, 'h0000, 'h12, 0, '0},
		'{0, 'h0000, 'h34, 0, '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  m_tlast;

	// parser model state
	logic [2:0]  prs_phase;
	logic [31:0] tag_acc;
	logic [1:0]  tag_ext_cnt;
	logic [15:0] len_acc;
	logic [1:0]  len_todo;
	logic        hdr_cons;
	logic [15:0] lvl_rem [LEVELS];
	logic        lvl_skip [LEVELS];
	int          nest;
	logic [15:0] val_todo;

	// results still owed by the block, oldest first
	item_t       due_results [$];
	item_t       got_item;
	item_t       want_item;

	// scratch byte queues for building buffers
	logic [7:0]  hdr_q [$];
	logic [7:0]  body_q [$];
	logic [7:0]  frame_q [$];

	int          n_bad = 0;
	int          n_results = 0;
	int          n_rand = 0;
	int          cycle_cnt = 0;
	bit          calm = 1'b0;
	bit          held = 1'b0;
	bit          paused = 1'b0;

	ber_tlv_stream_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic void clear_parser();
		int i;
		prs_phase   = PH_TAG1;
		tag_acc     = '0;
		tag_ext_cnt = '0;
		len_acc     = '0;
		len_todo    = '0;
		hdr_cons    = 1'b0;
		nest        = 0;
		val_todo    = '0;
		for (i = 0; i < LEVELS; i++) begin
			lvl_rem[i]  = '0;
			lvl_skip[i] = 1'b0;
		end
	endfunction

	// advance the parser model by one byte and return the result it gives
	function automatic item_t parse_byte(input logic [7:0] b, input logic st,
			input logic [15:0] blen);
		item_t       r;
		int          d;
		int          i;
		logic [15:0] left;
		logic [2:0]  err;
		logic        done;
		r    = '0;
		err  = ERR_NONE;
		done = 1'b0;
		if (st) begin
			clear_parser();
			lvl_rem[0] = blen;
		end
		if (lvl_rem[0] == 0) begin
			r.kind = KIND_SKIP;
			return r;
		end
		d = nest;
		r.depth = d[3:0];
		// every open level up to the current one loses a byte
		for (i = 0; i <= d; i++)
			if (lvl_rem[i] != 0) lvl_rem[i]--;
		left = lvl_rem[d];

		if (lvl_skip[d]) begin
			r.kind = KIND_SKIP;
		end else begin
			case (prs_phase)
				PH_TAGN: begin
					tag_acc     = {tag_acc[23:0], b};
					tag_ext_cnt = tag_ext_cnt + 2'd1;
					if (b[7] && tag_ext_cnt == TAG_EXTRA_MAX) begin
						err = ERR_TAG_LONG;
					end else begin
						if (!b[7]) prs_phase = PH_LEN1;
						if (left == 0) err = ERR_TRUNC;
					end
				end
				PH_LEN1: begin
					if (!b[7]) begin
						len_acc = {8'h00, b};
						done    = 1'b1;
					end else if (b == LEN_LONG_1 || b == LEN_LONG_2) begin
						len_acc   = '0;
						len_todo  = b[1:0];
						prs_phase = PH_LENN;
						if (left == 0) err = ERR_TRUNC;
					end else begin
						err = ERR_BAD_LEN;
					end
				end
				PH_LENN: begin
					len_acc = {len_acc[7:0], b};
					if (len_todo != 0) len_todo--;
					if (len_todo == 0) done = 1'b1;
					else if (left == 0) err = ERR_TRUNC;
				end
				PH_VALUE: begin
					r.kind       = KIND_VALUE;
					r.value_byte = b;
					if (val_todo != 0) val_todo--;
					if (val_todo == 0) prs_phase = PH_TAG1;
				end
				default: begin
					tag_acc     = {24'h0, b};
					tag_ext_cnt = '0;
					hdr_cons    = b[5];
					prs_phase   = ((b & TAG_NUM_MASK) == TAG_NUM_MASK) ? PH_TAGN : PH_LEN1;
					if (left == 0) err = ERR_TRUNC;
				end
			endcase
		end

		// header complete: open a level, start a value, or flag overrun
		if (done) begin
			if (len_acc > left) begin
				err = ERR_OVERRUN;
			end else begin
				r.kind        = KIND_HDR_DONE;
				r.tag         = tag_acc;
				r.length      = len_acc;
				r.constructed = hdr_cons;
				prs_phase     = PH_TAG1;
				if (len_acc != 0) begin
					if (hdr_cons && d < MAX_DEPTH) begin
						nest            = d + 1;
						lvl_rem[d + 1]  = len_acc;
						lvl_skip[d + 1] = 1'b0;
					end else begin
						val_todo  = len_acc;
						prs_phase = PH_VALUE;
					end
				end
			end
		end

		if (err != ERR_NONE) begin
			r.kind       = KIND_ERROR;
			r.error_code = err;
			lvl_skip[d]  = 1'b1;
			prs_phase    = PH_TAG1;
		end

		// close every level that has run out
		while (nest > 0 && lvl_rem[nest] == 0) begin
			lvl_skip[nest] = 1'b0;
			nest--;
			prs_phase = PH_TAG1;
		end
		if (lvl_rem[0] == 0) begin
			r.buffer_end = 1'b1;
			prs_phase    = PH_TAG1;
		end
		return r;
	endfunction

	// tag of 1..4 bytes (now and then one continuation too many), then length
	function automatic void make_hdr(input logic cons, input int len);
		int         r;
		int         ext;
		int         i;
		logic [7:0] b;
		hdr_q.delete();
		r   = $urandom_range(99);
		ext = (r < 55) ? 0 : (r < 75) ? 1 : (r < 88) ? 2 : (r < 97) ? 3 : 4;
		b    = 8'($urandom_range(255));
		b[5] = cons;
		if (ext > 0) b[4:0] = 5'h1F;
		else if (b[4:0] == 5'h1F) b[4:0] = 5'h1E;
		hdr_q.push_back(b);
		for (i = 1; i <= ext && i <= 3; i++) begin
			b    = 8'($urandom_range(255));
			b[7] = (i < ext);
			hdr_q.push_back(b);
		end
		r = $urandom_range(99);
		if (len < 128 && r < 70) begin
			hdr_q.push_back(8'(len));
		end else if (len < 256 && r < 85) begin
			hdr_q.push_back(LEN_LONG_1);
			hdr_q.push_back(8'(len));
		end else begin
			hdr_q.push_back(LEN_LONG_2);
			hdr_q.push_back(8'(len >> 8));
			hdr_q.push_back(8'(len));
		end
	endfunction

	// primitive element, mostly short; sometimes an empty constructed one
	function automatic void add_prim();
		int   n;
		int   i;
		int   r;
		logic cons;
		cons = ($urandom_range(9) == 0);
		r    = $urandom_range(99);
		if (cons) n = 0;
		else if (r < 85) n = $urandom_range(6);
		else if (r < 97) n = $urandom_range(7, 40);
		else n = $urandom_range(120, 300);
		make_hdr(cons, n);
		for (i = 0; i < hdr_q.size(); i++) body_q.push_back(hdr_q[i]);
		for (i = 0; i < n; i++) body_q.push_back(8'($urandom_range(255)));
	endfunction

	function automatic void wrap_body();
		int i;
		make_hdr(1'b1, body_q.size());
		for (i = hdr_q.size() - 1; i >= 0; i--) body_q.push_front(hdr_q[i]);
	endfunction

	// one top-level element, nested from shallow to past the depth limit
	function automatic void add_element();
		int i;
		int r;
		int lv;
		body_q.delete();
		r = $urandom_range(1, 3);
		for (i = 0; i < r; i++) add_prim();
		r  = $urandom_range(99);
		lv = (r < 30) ? 0 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(7, 10);
		for (i = 0; i < lv; i++) begin
			if ($urandom_range(3) == 0) add_prim();
			wrap_body();
		end
		for (i = 0; i < body_q.size(); i++) frame_q.push_back(body_q[i]);
	endfunction

	// offer one byte, wait for it to be taken, then log the result it owes
	task automatic push_byte(input logic [7:0] b, input logic st, input logic [15:0] blen,
			input logic typed, input item_t want);
		item_t model_out;
		while (!calm && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {blen, b};
		s_tuser  <= st;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		model_out = parse_byte(b, st, blen);
		due_results.push_back(typed ? want : model_out);
	endtask

	// build and send one buffer; about a quarter are damaged or pure noise
	task automatic send_buffer();
		int i;
		int n;
		int mode;
		int blen;
		frame_q.delete();
		n = $urandom_range(1, 3);
		for (i = 0; i < n; i++) add_element();
		blen = frame_q.size();
		mode = $urandom_range(99);
		if (mode < 8) begin
			frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom_range(255));
		end else if (mode < 12 && blen > 1) begin
			// declared short: the tail arrives with no buffer active
			blen = $urandom_range(1, blen - 1);
		end else if (mode < 16) begin
			// declared long: the next start abandons this buffer
			blen = blen + $urandom_range(1, 20);
		end else if (mode < 20 && frame_q.size() > 1) begin
			n = $urandom_range(1, frame_q.size() - 1);
			while (frame_q.size() > n) void'(frame_q.pop_back());
		end else if (mode < 25) begin
			frame_q.delete();
			n = $urandom_range(4, 30);
			for (i = 0; i < n; i++) frame_q.push_back(8'($urandom_range(255)));
			blen = $urandom_range(1, 65535);
		end
		for (i = 0; i < frame_q.size(); i++)
			push_byte(frame_q[i], i == 0, (i == 0) ? 16'(blen) : 16'($urandom_range(65535)),
				1'b0, '0);
		n_rand += frame_q.size();
		// stray bytes between buffers
		if ($urandom_range(19) == 0)
			for (i = 0; i < 3; i++)
				push_byte(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)), 1'b0, '0);
	endtask

	// sender
	initial begin : drive_stimulus
		int k;
		clear_parser();
		while (arst_n !== 1'b1) @(posedge clk);
		for (k = 0; k < DIR_ROWS; k++)
			push_byte(DIR_TAB[k].data, DIR_TAB[k].start, DIR_TAB[k].blen,
				DIR_TAB[k].typed, DIR_TAB[k].want);
		while (n_rand < RAND_ITEMS) begin
			calm = (n_rand >= 700 && n_rand < 900);
			// once: let the parser drain completely before going on
			if (!paused && n_rand >= 400) begin
				paused = 1'b1;
				s_tvalid <= 1'b0;
				while (due_results.size() != 0) @(posedge clk);
			end
			send_buffer();
		end
		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (n_bad == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	// receiver: random stalls, plus one long hold so the skid buffer fills
	initial begin : drain_results
		int hold;
		forever begin
			@(posedge clk);
			if (!held && n_results >= 300) begin
				held = 1'b1;
				m_tready <= 1'b0;
				for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
			end
			m_tready <= calm || ($urandom_range(99) >= 7);
		end
	end

	function automatic string item_text(input item_t it);
		return $sformatf("kind=%0d tag=%h len=%h cons=%0d depth=%0d val=%h err=%0d end=%0d",
			it.kind, it.tag, it.length, it.constructed, it.depth, it.value_byte,
			it.error_code, it.buffer_end);
	endfunction

	task automatic note_fail(input string why, input item_t want, input item_t got);
		n_bad++;
		if (n_bad <= 10)
			$display("%0t %s: expected %s / got %s", $time, why, item_text(want), item_text(got));
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got_item.kind        = m_tuser;
			got_item.tag         = m_tdata[31:0];
			got_item.length      = m_tdata[47:32];
			got_item.constructed = m_tdata[48];
			got_item.depth       = m_tdata[52:49];
			got_item.value_byte  = m_tdata[60:53];
			got_item.error_code  = m_tdata[63:61];
			got_item.buffer_end  = m_tlast;
			n_results++;
			if (due_results.size() == 0) begin
				note_fail("result with nothing pending", '0, got_item);
			end else begin
				want_item = due_results.pop_front();
				if (got_item.kind !== want_item.kind || got_item.tag !== want_item.tag ||
						got_item.length !== want_item.length ||
						got_item.constructed !== want_item.constructed ||
						got_item.depth !== want_item.depth ||
						got_item.value_byte !== want_item.value_byte ||
						got_item.error_code !== want_item.error_code ||
						got_item.buffer_end !== want_item.buffer_end)
					note_fail("mismatch", want_item, got_item);
			end
		end
	end

endmodule
